// ----- design/pbf_pkg.sv -----
// Package for the bond force block: widths, register indexes, Q format constants.
// No dependencies.
`timescale 1ns / 1ps
package pbf_pkg;
  localparam int FRAC = 40;
  localparam int CFG_IDX_W = 3;
  localparam logic [2:0] REG_SPRING = 3'd0;
  localparam logic [2:0] REG_HORIZON = 3'd1;
  localparam logic [2:0] REG_BASE = 3'd2;
  localparam logic [2:0] REG_SLOPE = 3'd3;
  localparam logic [2:0] REG_LATTICE = 3'd4;
  localparam logic [63:0] ONE_Q = 64'h0000_0100_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam int QUEUE_DEPTH = 2;

  // Classified bond handed from the front part to the back part.
  typedef struct packed {
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
    logic bond_broken;
    logic alive;
    logic last;
    logic signed [63:0] lim;
  } bond_res_t;

  function automatic logic signed [63:0] to_signed(input logic [63:0] m, input logic neg);
    logic signed [63:0] r;
    if (neg) r = m[63] ? S64_MIN : -$signed(m);
    else r = m[63] ? S64_MAX : $signed(m);
    return r;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction
endpackage

// ----- design/pbf_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read (queue storage).
// No dependencies.
`timescale 1ns / 1ps
module pbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/pbf_mul.sv -----
// Sequential 64x64 unsigned multiplier, 32x32 partial product per cycle.
// No dependencies.
`timescale 1ns / 1ps
module pbf_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic done,
  output logic [127:0] prod
);
  logic [2:0] step;
  logic busy;
  logic [63:0] ra, rb;
  logic [63:0] pp;
  logic [31:0] ha, hb;
  assign ha = step[1] ? ra[63:32] : ra[31:0];
  assign hb = step[0] ? rb[63:32] : rb[31:0];
  always_ff @(posedge clk) begin
    pp <= 64'(ha) * 64'(hb);
  end
  // stage 1 registers a partial product in pp, then the next cycle accumulates it into prod
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        ra <= a;
        rb <= b;
        prod <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step != 3'd0) begin
          case (step - 3'd1)
            3'd0: prod <= prod + 128'(pp);
            3'd1: prod <= prod + (128'(pp) << 32);
            3'd2: prod <= prod + (128'(pp) << 32);
            3'd3: prod <= prod + (128'(pp) << 64);
            default: prod <= prod;
          endcase
        end
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/pbf_div.sv -----
// Restoring divider: (hi:lo) / d one quotient bit per cycle, saturating.
// No dependencies.
`timescale 1ns / 1ps
module pbf_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] d,
  output logic done,
  output logic [63:0] q
);
  logic busy;
  logic [6:0] cnt;
  logic [63:0] rem, rlo, rd;
  logic [64:0] sh;
  assign sh = {rem, rlo[63]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rd <= d;
        if (hi >= d) begin
          q <= '1;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt <= 7'd0;
          rem <= hi;
          rlo <= lo;
          q <= '0;
        end
      end else if (busy) begin
        rlo <= rlo << 1;
        if (sh >= {1'b0, rd}) begin
          rem <= 64'(sh - {1'b0, rd});
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= sh[63:0];
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/pbf_front.sv -----
// Front part: length, stretch, scale, force and candidate limit of one bond.
// Uses pbf_pkg, pbf_mul, pbf_div.
`timescale 1ns / 1ps
module pbf_front (
  input  logic clk,
  input  logic rst,
  input  logic [63:0] spring_constant,
  input  logic [63:0] horizon,
  input  logic signed [63:0] base_critical_stretch,
  input  logic signed [63:0] stretch_slope,
  input  logic [63:0] lattice_constant,
  input  logic in_valid,
  output logic in_ready,
  input  logic [511:0] in_data,
  input  logic in_last,
  output logic res_valid,
  input  logic res_ready,
  output pbf_pkg::bond_res_t res
);
  localparam logic [4:0] S_IDLE = 5'd0, S_SQ = 5'd1, S_SQW = 5'd2, S_RT = 5'd3,
    S_RTW = 5'd4, S_ST = 5'd5, S_STW = 5'd6, S_SC = 5'd7, S_SCW = 5'd8,
    S_K1 = 5'd9, S_K1W = 5'd10, S_K2 = 5'd11, S_K2W = 5'd12, S_K3 = 5'd13,
    S_K3W = 5'd14, S_FM = 5'd15, S_FMW = 5'd16, S_FD = 5'd17, S_FDW = 5'd18,
    S_LM = 5'd19, S_LMW = 5'd20, S_OUT = 5'd21;
  logic [4:0] state;
  logic signed [63:0] d [3];
  logic [63:0] r0, vf, r, bit_m, sc, rkm;
  logic [63:0] dr_mag;
  logic signed [63:0] own, par, st, rk;
  logic drneg;
  logic [1:0] k;
  logic [127:0] sq;
  logic mstart, mdone, dstart, ddone;
  logic [63:0] ma, mb, dhi, dlo, dd, dq;
  logic [127:0] mp;
  logic [63:0] t;
  logic [63:0] qm;
  logic [63:0] diff, n;
  logic up;

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(pbf_pkg::S64_MAX)) return pbf_pkg::S64_MAX;
    if (s < 65'(pbf_pkg::S64_MIN)) return pbf_pkg::S64_MIN;
    return s[63:0];
  endfunction

  pbf_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mp));
  pbf_div u_div (.clk, .rst, .start(dstart), .hi(dhi), .lo(dlo), .d(dd), .done(ddone),
    .q(dq));

  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign t = r | bit_m;
  assign qm = (mp[127:104] != '0) ? '1 : mp[103:40];
  assign up = horizon >= r0;
  assign diff = up ? horizon - r0 : r0 - horizon;
  assign n = up ? lattice_constant + (diff << 1) : lattice_constant - (diff << 1);
  assign dr_mag = (r < r0) ? r0 - r : r - r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstart <= 1'b0;
      dstart <= 1'b0;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          d[0] <= in_data[63:0];
          d[1] <= in_data[127:64];
          d[2] <= in_data[191:128];
          r0 <= {1'b0, in_data[254:192]};
          vf <= {1'b0, in_data[317:255]};
          own <= in_data[381:318];
          par <= in_data[445:382];
          res.alive <= in_data[446];
          res.last <= in_last;
          res.force_x <= '0;
          res.force_y <= '0;
          res.force_z <= '0;
          res.bond_broken <= 1'b0;
          res.lim <= '0;
          sq <= '0;
          k <= 2'd0;
          state <= in_data[446] ? S_SQ : S_OUT;
        end
        S_SQ: begin
          ma <= pbf_pkg::mag(d[k]);
          mb <= pbf_pkg::mag(d[k]);
          mstart <= 1'b1;
          state <= S_SQW;
        end
        S_SQW: if (mdone) begin
          sq <= sq + mp;
          if (k == 2'd2) begin
            r <= '0;
            bit_m <= 64'h8000_0000_0000_0000;
            state <= S_RT;
          end else begin
            k <= k + 2'd1;
            state <= S_SQ;
          end
        end
        S_RT: begin
          ma <= t;
          mb <= t;
          mstart <= 1'b1;
          state <= S_RTW;
        end
        S_RTW: if (mdone) begin
          if (mp <= sq) r <= t;
          bit_m <= bit_m >> 1;
          state <= (bit_m[0]) ? S_ST : S_RT;
        end
        S_ST: begin
          drneg <= r < r0;
          st <= '0;
          state <= (r0 != '0) ? S_STW : S_SC;
          if (r0 != '0) begin
            dhi <= dr_mag >> 24;
            dlo <= dr_mag << 40;
            dd <= r0;
            dstart <= 1'b1;
          end
        end
        S_STW: if (ddone) begin
          st <= pbf_pkg::to_signed(dq, drneg);
          state <= S_SC;
        end
        S_SC: begin
          sc <= pbf_pkg::ONE_Q;
          res.bond_broken <= st > ((own < par) ? own : par);
          if (lattice_constant != '0 && {diff, 1'b0} <= {1'b0, lattice_constant}) begin
            dhi <= n >> 24;
            dlo <= n << 40;
            dd <= lattice_constant << 1;
            dstart <= 1'b1;
            state <= S_SCW;
          end else state <= S_K1;
        end
        S_SCW: if (ddone) begin
          sc <= dq;
          state <= S_K1;
        end
        S_K1: begin
          ma <= spring_constant;
          mb <= vf;
          mstart <= 1'b1;
          state <= S_K1W;
        end
        S_K1W: if (mdone) begin
          rkm <= qm;
          state <= S_K2;
        end
        S_K2: begin
          ma <= rkm;
          mb <= sc;
          mstart <= 1'b1;
          state <= S_K2W;
        end
        S_K2W: if (mdone) begin
          rkm <= qm;
          state <= S_K3;
        end
        S_K3: begin
          ma <= rkm;
          mb <= pbf_pkg::mag(st);
          mstart <= 1'b1;
          state <= S_K3W;
        end
        S_K3W: if (mdone) begin
          rk <= pbf_pkg::to_signed(qm, st[63]);
          k <= 2'd0;
          state <= (r != '0) ? S_FM : S_LM;
        end
        S_FM: begin
          ma <= pbf_pkg::mag(rk);
          mb <= pbf_pkg::mag(d[k]);
          mstart <= 1'b1;
          state <= S_FMW;
        end
        S_FMW: if (mdone) begin
          dhi <= mp[127:64];
          dlo <= mp[63:0];
          dd <= r;
          dstart <= 1'b1;
          state <= S_FDW;
        end
        S_FDW: if (ddone) begin
          case (k)
            2'd0: res.force_x <= pbf_pkg::to_signed(dq, rk[63] == d[k][63]);
            2'd1: res.force_y <= pbf_pkg::to_signed(dq, rk[63] == d[k][63]);
            default: res.force_z <= pbf_pkg::to_signed(dq, rk[63] == d[k][63]);
          endcase
          if (k == 2'd2) state <= S_LM;
          else begin
            k <= k + 2'd1;
            state <= S_FM;
          end
        end
        S_LM: begin
          ma <= pbf_pkg::mag(stretch_slope);
          mb <= pbf_pkg::mag(st);
          mstart <= 1'b1;
          state <= S_LMW;
        end
        S_LMW: if (mdone) begin
          res.lim <= sat_sub(base_critical_stretch,
            pbf_pkg::to_signed(qm, stretch_slope[63] != st[63]));
          state <= S_OUT;
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/pbf_back.sv -----
// Back part: bond queue, running limit and output register.
// Uses pbf_pkg, pbf_ram.
`timescale 1ns / 1ps
module pbf_back (
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_ready,
  input  pbf_pkg::bond_res_t res,
  output logic out_valid,
  input  logic out_ready,
  output logic [263:0] out_data,
  output logic out_last
);
  localparam int AW = $clog2(pbf_pkg::QUEUE_DEPTH);
  localparam int W = $bits(pbf_pkg::bond_res_t);
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic [W-1:0] rdata;
  pbf_pkg::bond_res_t qh;
  logic rd_pend;
  logic signed [63:0] running_limit, nl;
  logic no_live_bond_yet, push, pop;

  pbf_ram #(.WIDTH(W), .DEPTH(pbf_pkg::QUEUE_DEPTH)) u_q (
    .clk, .we(push), .waddr(wp), .wdata(res), .raddr(rp), .rdata(rdata));

  assign res_ready = (cnt < (AW + 1)'(pbf_pkg::QUEUE_DEPTH));
  assign push = res_valid && res_ready;
  assign qh = rdata;
  // one read in flight; pop when the output slot frees
  assign pop = (cnt != '0) && !rd_pend && (!out_valid || out_ready);
  assign nl = (qh.alive && (no_live_bond_yet || qh.lim > running_limit)) ? qh.lim
            : running_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
      running_limit <= pbf_pkg::S64_MAX;
      no_live_bond_yet <= 1'b1;
    end else begin
      if (push) wp <= wp + 1'b1;
      cnt <= cnt + (AW + 1)'(push) - (AW + 1)'(pop);
      if (pop) rp <= rp + 1'b1;
      rd_pend <= pop;
      if (out_valid && out_ready) out_valid <= 1'b0;
      // read data is valid the cycle after the pop
      if (rd_pend) begin
        out_valid <= 1'b1;
        out_data <= {7'd0, (qh.last ? nl : 64'sd0), qh.bond_broken,
                     qh.force_z, qh.force_y, qh.force_x};
        out_last <= qh.last;
        if (qh.last) begin
          running_limit <= pbf_pkg::S64_MAX;
          no_live_bond_yet <= 1'b1;
        end else if (qh.alive) begin
          running_limit <= nl;
          no_live_bond_yet <= 1'b0;
        end
      end
    end
  end
endmodule

// ----- design/peridynamic_bond_force_top.sv -----
// Peridynamic bond force block, top level.
// Uses pbf_pkg, pbf_front, pbf_back.
//
// Usage: one bond per transfer on the s_axis channel; tlast marks the atom's last
// bond. Each bond yields one result on m_axis; m_axis_tlast is atom_done and the
// result then carries the atom's new critical-stretch limit.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while idle.
// Work for a live bond with nonzero length: the multiplier round trip repeated
// 64 times by the square root, five 64-step divides (stretch, scale, three force
// quotients) and ten further multiplies; the scale divide is skipped outside the
// horizon band. Dead bonds go straight from input to result.
// One bond is in the front part at a time, so the next input is taken only after
// the front finishes and its result is accepted by the back part. The back
// part holds a 2-entry queue and an output register, so the front keeps working
// while m_axis is stalled until the queue fills. Reset empties the queue, sets the
// running limit to its maximum and resets control and configuration registers.
`timescale 1ns / 1ps
module peridynamic_bond_force_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // disp_x, disp_y, disp_z, rest_length, partner_volume, own_limit, partner_limit,
  // bond_alive, zero fill
  input  logic [447:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // force_x, force_y, force_z, bond_broken, new_limit, zero fill
  output logic [263:0] m_axis_tdata,
  output logic m_axis_tlast
);
  logic [63:0] spring_constant, horizon, lattice_constant;
  logic signed [63:0] base_critical_stretch, stretch_slope;
  logic res_valid, res_ready;
  pbf_pkg::bond_res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_constant <= '0;
      horizon <= '0;
      base_critical_stretch <= '0;
      stretch_slope <= '0;
      lattice_constant <= pbf_pkg::ONE_Q;
    end else if (cfg_we) begin
      case (cfg_index)
        pbf_pkg::REG_SPRING: spring_constant <= {1'b0, cfg_data[62:0]};
        pbf_pkg::REG_HORIZON: horizon <= {1'b0, cfg_data[62:0]};
        pbf_pkg::REG_BASE: base_critical_stretch <= cfg_data;
        pbf_pkg::REG_SLOPE: stretch_slope <= cfg_data;
        pbf_pkg::REG_LATTICE: lattice_constant <= {1'b0, cfg_data[62:0]};
        default: ;
      endcase
    end
  end

  pbf_front u_front (
    .clk, .rst, .spring_constant, .horizon, .base_critical_stretch, .stretch_slope,
    .lattice_constant, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data({64'd0, s_axis_tdata}), .in_last(s_axis_tlast),
    .res_valid, .res_ready, .res);

  pbf_back u_back (
    .clk, .rst, .res_valid, .res_ready, .res, .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(m_axis_tdata), .out_last(m_axis_tlast));
endmodule
